// ===== design/tlpw_pkg.sv =====
// Shared types and constants for the two-level page table walker.
// Holds the transaction payload structs, operation and status codes and walk levels.
// No dependencies.
package tlpw_pkg;

  // Default size of the table memory in 32-bit words
  localparam int unsigned MEM_WORDS_DEF = 4096;

  // Width of a word address formed from a 32-bit byte address
  localparam int unsigned WORD_ADDR_W = 30;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_BASE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CMP_MASK = 1'b1;

  // Reset values of the configuration registers
  localparam logic [31:0] DIR_BASE_RST = 32'h0000_0000;
  localparam logic [11:0] CMP_MASK_RST = 12'hF9F;

  // Operation codes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CHECK = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISS    = 2'd1;
  localparam logic [1:0] ST_BAD_ARG = 2'd2;

  // Level where a walk stopped
  localparam logic [1:0] LVL_DIR   = 2'd0;
  localparam logic [1:0] LVL_TABLE = 2'd1;
  localparam logic [1:0] LVL_FRAME = 2'd2;

  // Entry bit positions
  localparam int unsigned BIT_PRESENT = 0;
  localparam int unsigned BIT_WRITE   = 1;
  localparam int unsigned BIT_USER    = 2;
  localparam int unsigned BIT_LARGE   = 7;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] virt_addr;
    logic [31:0] expect_phys;
    logic [11:0] expect_flags;
    logic [11:0] word_index;
    logic [31:0] word_data;
  } tlpw_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  stop_level;
    logic [31:0] entry_addr;
    logic [11:0] flags_out;
    logic        read_only;
    logic        user_page;
  } tlpw_out_t;

endpackage

// ===== design/tlpw_wrap.sv =====
// Shared word index reduction unit: computes a word address modulo the memory size.
// Three registered steps: reciprocal multiply, back multiply, subtract and correct.
// Depends on tlpw_pkg.
module tlpw_wrap #(
  parameter int unsigned MEM_WORDS = tlpw_pkg::MEM_WORDS_DEF,
  parameter int unsigned ADDR_W    = $clog2(MEM_WORDS)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [tlpw_pkg::WORD_ADDR_W-1:0] x,
  output logic                             done,
  output logic [ADDR_W-1:0]                idx
);
  import tlpw_pkg::*;

  localparam int unsigned X_W   = WORD_ADDR_W;
  localparam int unsigned Q_W   = X_W + 1 - ADDR_W;
  localparam int unsigned P1_W  = X_W + Q_W;
  localparam int unsigned RECIP = (32'd1 << X_W) / MEM_WORDS;

  logic [X_W-1:0]    x1_r, x2_r, x3_r;
  logic [P1_W-1:0]   prod1_r;
  logic [X_W-1:0]    prod2_r;
  logic [ADDR_W-1:0] idx_r;
  logic              v1_r, v2_r, v3_r, done_r;
  logic [Q_W-1:0]    q_est;
  logic [X_W-1:0]    rem;

  // Quotient estimate is the true quotient or one less
  assign q_est = prod1_r[P1_W-1 -: Q_W];
  // Remainder stays below twice the memory size
  assign rem   = x3_r - prod2_r;

  // Advance the step valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= start;
      v2_r   <= v1_r;
      v3_r   <= v2_r;
      done_r <= v3_r;
    end
  end

  // Carry the operand and the partial results
  always_ff @(posedge clk) begin
    if (start) begin
      x1_r <= x;
    end
    x2_r    <= x1_r;
    x3_r    <= x2_r;
    prod1_r <= P1_W'(x1_r) * P1_W'(RECIP);
    prod2_r <= X_W'(X_W'(q_est) * X_W'(MEM_WORDS));
    if (rem >= X_W'(MEM_WORDS)) begin
      idx_r <= ADDR_W'(rem - X_W'(MEM_WORDS));
    end else begin
      idx_r <= ADDR_W'(rem);
    end
  end

  assign done = done_r;
  assign idx  = idx_r;

endmodule

// ===== design/tlpw_mem.sv =====
// Table memory of 32-bit words with one shared address port and registered read data.
// Contents are undefined until written.
// Depends on tlpw_pkg.
module tlpw_mem #(
  parameter int unsigned MEM_WORDS = tlpw_pkg::MEM_WORDS_DEF,
  parameter int unsigned ADDR_W    = $clog2(MEM_WORDS)
) (
  input  logic              clk,
  input  logic              we,
  input  logic              re,
  input  logic [ADDR_W-1:0] addr,
  input  logic [31:0]       wdata,
  output logic [31:0]       rdata
);
  import tlpw_pkg::*;

  logic [31:0] mem [MEM_WORDS];
  logic [31:0] rdata_r;

  // Store a word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // Read a word into the output register
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/two_level_page_table_walker.sv =====
// Two-level page table walker top level: configuration registers, walk sequencer
// and output register. Depends on tlpw_pkg, tlpw_wrap and tlpw_mem.
//
//   channel | ports                       | direction | transaction
//   in      | in_valid, in_stall, in_data | inbound   | write, query or check request
//   out     | out_valid, out_stall, ...   | outbound  | one result per request
//   cfg     | cfg_we, cfg_index, cfg_data | inbound   | register write, no wait
//
// One request at a time. A table write passes through the three-step index reduction
// unit and then the memory write; a walk passes each entry through that unit and the
// registered memory read, ending at the directory entry for a 4 MB translation or a
// directory miss and at the table entry otherwise. Argument errors skip the walk. Reset
// clears control state and the configuration registers, not the table memory. A stalled
// result holds in the output register while the next request is already taken in.
module two_level_page_table_walker #(
  parameter int unsigned MEM_WORDS = tlpw_pkg::MEM_WORDS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  tlpw_pkg::tlpw_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output tlpw_pkg::tlpw_out_t                 out_data,
  input  logic                                cfg_we,
  input  logic [tlpw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [31:0]                         cfg_data
);
  import tlpw_pkg::*;

  localparam int unsigned ADDR_W = $clog2(MEM_WORDS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WIDX,
    S_PDE_ADDR,
    S_PDE,
    S_PTE_ADDR,
    S_PTE,
    S_FIN
  } state_t;

  state_t     state_r, state_nxt;
  tlpw_in_t   item_r, item_nxt;
  tlpw_out_t  out_r, out_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [31:0] pde_r, pde_nxt;
  logic       wk_ok_r, wk_ok_nxt;
  logic [1:0] wk_lvl_r, wk_lvl_nxt;
  logic [31:0] wk_addr_r, wk_addr_nxt;
  logic [11:0] wk_flags_r, wk_flags_nxt;

  logic [31:0] dir_base_r;
  logic [11:0] cmp_mask_r;

  logic                   wrap_start;
  logic [WORD_ADDR_W-1:0] wrap_x;
  logic                   wrap_done;
  logic [ADDR_W-1:0]      wrap_idx;
  logic                   mem_we, mem_re;
  logic [31:0]            mem_rdata;

  logic      in_acc;
  logic      unaligned;
  logic      out_free;
  tlpw_out_t fin;
  logic [11:0] diff;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_base_r <= DIR_BASE_RST;
      cmp_mask_r <= CMP_MASK_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DIR_BASE: dir_base_r <= cfg_data;
        CFG_CMP_MASK: cmp_mask_r <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && (state_r == S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // Check requests must be page aligned on both addresses
  assign unaligned = (in_data.virt_addr[11:0] != 12'd0) ||
                     (in_data.expect_phys[11:0] != 12'd0);

  // Form the result from the walk outcome
  always_comb begin
    fin  = '0;
    diff = (item_r.expect_flags ^ wk_flags_r) & cmp_mask_r;
    unique case (item_r.op)
      OP_WRITE: fin = '0;
      OP_QUERY: begin
        fin.stop_level = wk_lvl_r;
        fin.entry_addr = wk_addr_r;
        if (wk_ok_r) begin
          fin.status    = ST_OK;
          fin.flags_out = wk_flags_r;
          fin.read_only = !wk_flags_r[BIT_WRITE];
          fin.user_page = wk_flags_r[BIT_USER];
        end else begin
          fin.status = ST_MISS;
        end
      end
      OP_CHECK: begin
        if ((item_r.virt_addr[11:0] != 12'd0) || (item_r.expect_phys[11:0] != 12'd0)) begin
          fin.status = ST_BAD_ARG;
        end else begin
          fin.stop_level = wk_lvl_r;
          fin.entry_addr = wk_addr_r;
          if (!wk_ok_r || (wk_addr_r != item_r.expect_phys)) begin
            fin.status    = ST_MISS;
            fin.flags_out = item_r.expect_flags;
          end else begin
            fin.flags_out = diff;
            fin.status    = (diff != 12'd0) ? ST_MISS : ST_OK;
          end
        end
      end
      default: fin.status = ST_BAD_ARG;
    endcase
  end

  // Sequencer next state
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    pde_nxt       = pde_r;
    wk_ok_nxt     = wk_ok_r;
    wk_lvl_nxt    = wk_lvl_r;
    wk_addr_nxt   = wk_addr_r;
    wk_flags_nxt  = wk_flags_r;
    wrap_start    = 1'b0;
    wrap_x        = {dir_base_r[31:12], in_data.virt_addr[31:22]};
    mem_we        = 1'b0;
    mem_re        = 1'b0;

    // Drop the result once taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          item_nxt     = in_data;
          wk_ok_nxt    = 1'b0;
          wk_lvl_nxt   = LVL_DIR;
          wk_addr_nxt  = dir_base_r;
          wk_flags_nxt = 12'd0;
          priority if (in_data.op == OP_WRITE) begin
            wrap_start = 1'b1;
            wrap_x     = WORD_ADDR_W'(in_data.word_index);
            state_nxt  = S_WIDX;
          end else if (in_data.op == OP_QUERY || (in_data.op == OP_CHECK && !unaligned)) begin
            wrap_start = 1'b1;
            state_nxt  = S_PDE_ADDR;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_WIDX: begin
        if (wrap_done) begin
          mem_we    = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_PDE_ADDR: begin
        if (wrap_done) begin
          mem_re    = 1'b1;
          state_nxt = S_PDE;
        end
      end
      S_PDE: begin
        priority if (!mem_rdata[BIT_PRESENT]) begin
          state_nxt = S_FIN;
        end else if (mem_rdata[BIT_LARGE]) begin
          wk_ok_nxt    = 1'b1;
          wk_lvl_nxt   = LVL_FRAME;
          wk_addr_nxt  = {mem_rdata[31:22], item_r.virt_addr[21:0]};
          wk_flags_nxt = mem_rdata[11:0];
          state_nxt    = S_FIN;
        end else begin
          pde_nxt    = mem_rdata;
          wrap_start = 1'b1;
          wrap_x     = {mem_rdata[31:12], item_r.virt_addr[21:12]};
          state_nxt  = S_PTE_ADDR;
        end
      end
      S_PTE_ADDR: begin
        if (wrap_done) begin
          mem_re    = 1'b1;
          state_nxt = S_PTE;
        end
      end
      S_PTE: begin
        if (!mem_rdata[BIT_PRESENT]) begin
          wk_lvl_nxt  = LVL_TABLE;
          wk_addr_nxt = pde_r;
        end else begin
          wk_ok_nxt    = 1'b1;
          wk_lvl_nxt   = LVL_FRAME;
          wk_addr_nxt  = {mem_rdata[31:12], item_r.virt_addr[11:0]};
          wk_flags_nxt = mem_rdata[11:0];
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // Hold until the output register is free
        if (out_free) begin
          out_nxt       = fin;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r     <= item_nxt;
    out_r      <= out_nxt;
    pde_r      <= pde_nxt;
    wk_ok_r    <= wk_ok_nxt;
    wk_lvl_r   <= wk_lvl_nxt;
    wk_addr_r  <= wk_addr_nxt;
    wk_flags_r <= wk_flags_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  tlpw_wrap #(
    .MEM_WORDS (MEM_WORDS),
    .ADDR_W    (ADDR_W)
  ) u_wrap (
    .clk   (clk),
    .rst_n (rst_n),
    .start (wrap_start),
    .x     (wrap_x),
    .done  (wrap_done),
    .idx   (wrap_idx)
  );

  tlpw_mem #(
    .MEM_WORDS (MEM_WORDS),
    .ADDR_W    (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (wrap_idx),
    .wdata (item_r.word_data),
    .rdata (mem_rdata)
  );

endmodule

// ===== test/two_level_page_table_walker_test.sv =====
// Self-checking testbench for the two-level page table walker: table writes, translations
// and mapping checks under random idling, predicted and compared result by result.
// Depends on tlpw_pkg and two_level_page_table_walker.
module two_level_page_table_walker_test;
  import tlpw_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned DIRECTED_ITEMS = 23;
  localparam int unsigned PHASE_ITEMS = 126;
  localparam int unsigned PHASES = 5;
  localparam int unsigned SETTLE_CYCLES = 30;
  localparam int unsigned IDLE_LIMIT = 3000;
  localparam int unsigned HOLD_AT = 250;
  localparam int unsigned LONG_HOLD = 200;

  // Predicts walk results and holds the ones not yet returned
  class walker_scoreboard;
    localparam int unsigned WORDS = tlpw_pkg::MEM_WORDS_DEF;
    logic [31:0] table_words[WORDS];
    bit written[WORDS];
    logic [31:0] dir_base = tlpw_pkg::DIR_BASE_RST;
    logic [11:0] cmp_mask = tlpw_pkg::CMP_MASK_RST;
    tlpw_pkg::tlpw_out_t walk_results[$];
    int errors = 0;

    // Word selected by a table address and an entry index; high bits wrap
    function int unsigned entry_word(logic [31:0] table_addr, logic [31:0] index);
      return (((table_addr & 32'hFFFF_F000) >> 2) + (index & 32'h3FF)) % WORDS;
    endfunction

    function void set_register(logic [tlpw_pkg::CFG_IDX_W-1:0] index, logic [31:0] value);
      if (index == tlpw_pkg::CFG_DIR_BASE) dir_base = value;
      else cmp_mask = value[11:0];
    endfunction

    // Walk directory and table; return 1 when a frame is reached
    function bit walk_tables(logic [31:0] va, output logic [1:0] level,
                             output logic [31:0] addr, output logic [11:0] flags);
      logic [31:0] pde, pte;
      level = tlpw_pkg::LVL_DIR;
      addr = dir_base;
      flags = '0;
      pde = table_words[entry_word(dir_base, va >> 22)];
      if (!pde[tlpw_pkg::BIT_PRESENT]) return 1'b0;
      if (pde[tlpw_pkg::BIT_LARGE]) begin
        addr = {pde[31:22], va[21:0]};
        flags = pde[11:0];
        level = tlpw_pkg::LVL_FRAME;
        return 1'b1;
      end
      pte = table_words[entry_word(pde, va >> 12)];
      if (!pte[tlpw_pkg::BIT_PRESENT]) begin
        level = tlpw_pkg::LVL_TABLE;
        addr = pde;
        return 1'b0;
      end
      addr = {pte[31:12], va[11:0]};
      flags = pte[11:0];
      level = tlpw_pkg::LVL_FRAME;
      return 1'b1;
    endfunction

    // Apply an accepted request and queue the result it must produce
    function void note_request(tlpw_pkg::tlpw_in_t req);
      tlpw_pkg::tlpw_out_t res;
      bit ok;
      logic [1:0] level;
      logic [31:0] addr;
      logic [11:0] flags;
      res = '0;
      case (req.op)
        tlpw_pkg::OP_WRITE: begin
          table_words[req.word_index % WORDS] = req.word_data;
          written[req.word_index % WORDS] = 1'b1;
        end
        tlpw_pkg::OP_QUERY: begin
          ok = walk_tables(req.virt_addr, level, addr, flags);
          res.stop_level = level;
          res.entry_addr = addr;
          if (ok) begin
            res.flags_out = flags;
            res.read_only = !flags[tlpw_pkg::BIT_WRITE];
            res.user_page = flags[tlpw_pkg::BIT_USER];
          end else begin
            res.status = tlpw_pkg::ST_MISS;
          end
        end
        tlpw_pkg::OP_CHECK: begin
          if (req.virt_addr[11:0] != 0 || req.expect_phys[11:0] != 0) begin
            res.status = tlpw_pkg::ST_BAD_ARG;
          end else begin
            ok = walk_tables(req.virt_addr, level, addr, flags);
            res.stop_level = level;
            res.entry_addr = addr;
            if (!ok || addr != req.expect_phys) begin
              res.status = tlpw_pkg::ST_MISS;
              res.flags_out = req.expect_flags;
            end else begin
              res.flags_out = (req.expect_flags ^ flags) & cmp_mask;
              res.status = (res.flags_out != 0) ? tlpw_pkg::ST_MISS : tlpw_pkg::ST_OK;
            end
          end
        end
        default: res.status = tlpw_pkg::ST_BAD_ARG;
      endcase
      walk_results.push_back(res);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    // Compare a returned result with the oldest prediction
    function void check_result(tlpw_pkg::tlpw_out_t got);
      tlpw_pkg::tlpw_out_t want;
      if (walk_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = walk_results.pop_front();
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("stop_level", 32'(want.stop_level), 32'(got.stop_level));
      compare_field("entry_addr", want.entry_addr, got.entry_addr);
      compare_field("flags_out", 32'(want.flags_out), 32'(got.flags_out));
      compare_field("read_only", 32'(want.read_only), 32'(got.read_only));
      compare_field("user_page", 32'(want.user_page), 32'(got.user_page));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  tlpw_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  tlpw_out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  walker_scoreboard sb = new;
  bit quiet_tail = 1'b0;
  int send_idle_odds = 4;
  int unsigned requests_sent = 0;
  logic [31:0] last_va = '0;

  two_level_page_table_walker i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic tlpw_in_t random_request();
    tlpw_in_t req;
    req.op = 2'($urandom);
    req.virt_addr = $urandom;
    req.expect_phys = $urandom;
    req.expect_flags = 12'($urandom);
    req.word_index = 12'($urandom);
    req.word_data = $urandom;
    return req;
  endfunction

  // Random entry, mostly present; directory entries sometimes map 4 MB
  function automatic logic [31:0] random_entry(bit dir_level);
    logic [31:0] entry;
    entry = $urandom;
    entry[BIT_PRESENT] = ($urandom_range(0, 7) != 0);
    if (dir_level) entry[BIT_LARGE] = ($urandom_range(0, 2) == 0);
    return entry;
  endfunction

  // Offer one transaction, after an optional gap, and hold it until taken
  task automatic send_request(tlpw_in_t req);
    int gap;
    gap = 0;
    if (!quiet_tail && send_idle_odds != 0 && $urandom_range(0, send_idle_odds) == 0)
      gap = $urandom_range(1, 9);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.note_request(req);
    requests_sent++;
  endtask

  task automatic send_write(int unsigned index, logic [31:0] data);
    tlpw_in_t req;
    req = random_request();
    req.op = OP_WRITE;
    req.word_index = 12'(index);
    req.word_data = data;
    send_request(req);
  endtask

  task automatic send_op(logic [1:0] op, logic [31:0] va, logic [31:0] pa, logic [11:0] ef);
    tlpw_in_t req;
    req = random_request();
    req.op = op;
    req.virt_addr = va;
    req.expect_phys = pa;
    req.expect_flags = ef;
    send_request(req);
  endtask

  // Fill any table word the walk of va would read that was never written
  task automatic prepare_walk(logic [31:0] va);
    int unsigned word;
    logic [31:0] pde;
    word = sb.entry_word(sb.dir_base, va >> 22);
    if (!sb.written[word]) send_write(word, random_entry(1'b1));
    pde = sb.table_words[word];
    if (pde[BIT_PRESENT] && !pde[BIT_LARGE]) begin
      word = sb.entry_word(pde, va >> 12);
      if (!sb.written[word]) send_write(word, random_entry(1'b0));
    end
  endtask

  // One random step: noise, an unused op, a translation or a mapping check
  task automatic random_action();
    int pick;
    bit ok;
    logic [31:0] va, pa, addr;
    logic [1:0] level;
    logic [11:0] flags, ef;
    pick = $urandom_range(0, 99);
    va = ($urandom_range(0, 2) == 0) ? {last_va[31:12], 12'($urandom)} : $urandom;
    if (pick < 12) begin
      send_write($urandom_range(0, 4095), $urandom);
    end else if (pick < 16) begin
      send_op(OP_UNUSED, $urandom, $urandom, 12'($urandom));
    end else if (pick < 48) begin
      prepare_walk(va);
      send_op(OP_QUERY, va, $urandom, 12'($urandom));
    end else begin
      va[11:0] = '0;
      prepare_walk(va);
      ok = sb.walk_tables(va, level, addr, flags);
      pa = (ok && $urandom_range(0, 3) != 0) ? addr : {$urandom, 12'h000};
      case ($urandom_range(0, 3))
        0: ef = flags;
        1: ef = flags ^ 12'h060;
        2: ef = flags ^ 12'(1 << $urandom_range(0, 11));
        default: ef = 12'($urandom);
      endcase
      if (pick < 56) begin
        if ($urandom_range(0, 1) != 0) va[11:0] = 12'($urandom_range(1, 4095));
        else pa[11:0] = 12'($urandom_range(1, 4095));
      end
      send_op(OP_CHECK, va, pa, ef);
    end
    last_va = va;
  endtask

  // Stop offering and wait for every outstanding result, then let the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.walk_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(logic [31:0] base, logic [31:0] mask_word);
    cfg_we <= 1'b1;
    cfg_index <= CFG_DIR_BASE;
    cfg_data <= base;
    @(posedge clk);
    sb.set_register(CFG_DIR_BASE, base);
    cfg_index <= CFG_CMP_MASK;
    cfg_data <= mask_word;
    @(posedge clk);
    sb.set_register(CFG_CMP_MASK, mask_word);
    cfg_we <= 1'b0;
  endtask

  // Result side: check each accepted result, stall in bursts and once for a long stretch
  initial begin
    int burst, hold, mode_left, odds;
    int unsigned seen;
    burst = 0;
    hold = 0;
    mode_left = 0;
    odds = 0;
    seen = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid === 1'b1 && !out_stall) begin
        sb.check_result(out_data);
        seen++;
        if (seen == HOLD_AT) hold = LONG_HOLD;
      end
      if (mode_left == 0) begin
        mode_left = 64;
        odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 6);
      end
      mode_left--;
      if (hold == 0 && burst == 0 && !quiet_tail && odds != 0 && $urandom_range(0, odds) == 0)
        burst = $urandom_range(1, 9);
      out_stall <= (hold != 0 || burst != 0);
      if (hold != 0) hold--;
      else if (burst != 0) burst--;
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  initial begin
    int unsigned idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) idle = 0;
      else idle++;
    end
    $display("%0t: watchdog, no transaction for %0d cycles", $time, IDLE_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // Stimulus: directed walks under reset settings, then random phases
  initial begin
    int unsigned actions;
    logic [11:0] mask;
    actions = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directory miss
    send_write(0, 32'h0000_0000);
    send_op(OP_QUERY, 32'h0000_0ABC, $urandom, 12'($urandom));
    // Table miss, then a 4 KB hit with writable, user, accessed and dirty set
    send_write(1, 32'h0000_1003);
    send_write(1024 + 5, 32'h0000_0000);
    send_op(OP_QUERY, 32'h0040_5123, $urandom, 12'($urandom));
    send_write(1024 + 6, 32'hABCD_E067);
    send_op(OP_QUERY, 32'h0040_6FFF, $urandom, 12'($urandom));
    // Read-only 4 MB page at the top of memory
    send_write(2, 32'hFFC0_0085);
    send_op(OP_QUERY, 32'h00BF_FFFF, $urandom, 12'($urandom));
    // Checks: match, masked-out difference, flag difference, wrong address
    send_op(OP_CHECK, 32'h0040_6000, 32'hABCD_E000, 12'h067);
    send_op(OP_CHECK, 32'h0040_6000, 32'hABCD_E000, 12'h007);
    send_op(OP_CHECK, 32'h0040_6000, 32'hABCD_E000, 12'h065);
    send_op(OP_CHECK, 32'h0040_6000, 32'hABCD_F000, 12'h067);
    // Unaligned virtual and physical addresses, failed walk, 4 MB match
    send_op(OP_CHECK, 32'h0040_6001, 32'hABCD_E000, 12'h067);
    send_op(OP_CHECK, 32'h0040_6000, 32'hABCD_E800, 12'h067);
    send_op(OP_CHECK, 32'h0000_0000, 32'h0000_0000, 12'hFFF);
    send_op(OP_CHECK, 32'h0080_0000, 32'hFFC0_0000, 12'h085);
    send_op(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
    // All-ones entries and table addresses whose high bits wrap
    send_write(1023, 32'hFFFF_FFFF);
    send_op(OP_QUERY, 32'hFFFF_FFFF, $urandom, 12'($urandom));
    send_write(4095, 32'hFFFF_FFFF);
    send_write(3, 32'hFFFF_F001);
    send_op(OP_QUERY, 32'h00FF_FABC, $urandom, 12'($urandom));

    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      mask = 12'($urandom);
      case (phase)
        0: configure(32'hFFFF_FFFF, {20'($urandom), 12'hFFF});
        1: configure($urandom, {20'($urandom), 12'h000});
        2: configure($urandom, {20'($urandom), mask});
        3: configure(32'h0000_0000, {20'h0, CMP_MASK_RST});
        default: configure($urandom, {20'($urandom), mask});
      endcase
      if (phase == PHASES - 1) quiet_tail = 1'b1;
      while (requests_sent < DIRECTED_ITEMS + (phase + 1) * PHASE_ITEMS) begin
        if (actions % 32 == 0)
          send_idle_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 6);
        actions++;
        random_action();
      end
    end

    settle();
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
